FILE: src/ffbp_pkg.sv
package ffbp_pkg;

   localparam int FILL_W = 16;
   localparam int IDX_OUT_W = 8;
   localparam int USED_W = 9;
   localparam int SUM_W = 40;
   localparam int SQ_W = 2 * FILL_W;
   localparam int DEFAULT_MAX_BINS = 256;
   localparam logic [FILL_W-1:0] CAP_RESET = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SQ_OLD,
      ST_SQ_NEW,
      ST_SQ_ADD,
      ST_DONE
   } ctrl_state_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_LOAD_OLD,
      SQ_SUB,
      SQ_ADD,
      SQ_CLEAR
   } sq_op_type;

   typedef struct packed {
      sq_op_type         op;
      logic [FILL_W-1:0] old_fill;
      logic [FILL_W-1:0] new_fill;
   } sq_cmd_type;

   typedef struct packed {
      logic [IDX_OUT_W-1:0] bin_sel;
      logic                 opened_new_bin;
      logic [USED_W-1:0]    bins_used;
      logic                 overflow;
      logic                 packing_done;
   } result_type;

endpackage

FILE: src/ffbp_fill_mem.sv
module ffbp_fill_mem #(
   parameter int DEPTH = ffbp_pkg::DEFAULT_MAX_BINS,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [ffbp_pkg::FILL_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [ffbp_pkg::FILL_W-1:0] rd_data
);
   import ffbp_pkg::*;

   logic [FILL_W-1:0] mem_ff [DEPTH];
   logic [FILL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/ffbp_sq_acc.sv
module ffbp_sq_acc (
   input  logic                       clock,
   input  logic                       reset,
   input  ffbp_pkg::sq_cmd_type       cmd,
   output logic [ffbp_pkg::SUM_W-1:0] square_sum
);
   import ffbp_pkg::*;

   logic [FILL_W-1:0] mul_op;
   logic [SQ_W-1:0]   prod;
   logic [SQ_W-1:0]   sq_ff;
   logic [SQ_W-1:0]   sq_in;
   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  sum_in;

   always_comb begin
      mul_op = (cmd.op == SQ_SUB) ? cmd.new_fill : cmd.old_fill;
      prod = SQ_W'(mul_op) * SQ_W'(mul_op);
      sq_in = sq_ff;
      sum_in = sum_ff;
      case (cmd.op)
         SQ_LOAD_OLD: begin
            sq_in = prod;
         end
         SQ_SUB: begin
            sum_in = sum_ff - SUM_W'(sq_ff);
            sq_in = prod;
         end
         SQ_ADD: begin
            sum_in = sum_ff + SUM_W'(sq_ff);
         end
         SQ_CLEAR: begin
            sum_in = '0;
         end
         default: begin
            sq_in = sq_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign square_sum = sum_ff;

endmodule

FILE: src/ffbp_scan.sv
module ffbp_scan #(
   parameter int MAX_BINS = ffbp_pkg::DEFAULT_MAX_BINS,
   parameter int BIN_W = $clog2(MAX_BINS),
   parameter int CNT_W = $clog2(MAX_BINS + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ffbp_pkg::FILL_W-1:0] capacity,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ffbp_pkg::FILL_W-1:0] req_size,
   input  logic                        req_last,
   output logic                        mem_rd_en,
   output logic [BIN_W-1:0]            mem_rd_addr,
   input  logic [ffbp_pkg::FILL_W-1:0] mem_rd_data,
   output logic                        mem_wr_en,
   output logic [BIN_W-1:0]            mem_wr_addr,
   output logic [ffbp_pkg::FILL_W-1:0] mem_wr_data,
   output ffbp_pkg::sq_cmd_type        sq_cmd,
   input  logic                        out_free,
   output logic                        res_valid,
   output ffbp_pkg::result_type        result
);
   import ffbp_pkg::*;

   ctrl_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              pend_ff, pend_in;
   logic [BIN_W-1:0]  pend_idx_ff, pend_idx_in;
   logic [BIN_W-1:0]  chosen_ff, chosen_in;
   logic [FILL_W-1:0] size_ff, size_in;
   logic              last_ff, last_in;
   logic [FILL_W-1:0] old_ff, old_in;
   logic [FILL_W-1:0] new_ff, new_in;
   logic              opened_ff, opened_in;
   logic              ovf_ff, ovf_in;
   logic              issue;
   logic              fit;
   logic [31:0]       chosen_wide;
   logic [31:0]       count_wide;

   always_comb begin
      issue = rd_idx_ff < count_ff;
      fit = ({1'b0, mem_rd_data} + {1'b0, size_ff}) <= {1'b0, capacity};
      state_in = state_ff;
      count_in = count_ff;
      rd_idx_in = rd_idx_ff;
      pend_in = pend_ff;
      pend_idx_in = pend_idx_ff;
      chosen_in = chosen_ff;
      size_in = size_ff;
      last_in = last_ff;
      old_in = old_ff;
      new_in = new_ff;
      opened_in = opened_ff;
      ovf_in = ovf_ff;
      req_tready = 1'b0;
      mem_rd_en = 1'b0;
      mem_rd_addr = rd_idx_ff[BIN_W-1:0];
      mem_wr_en = 1'b0;
      mem_wr_addr = chosen_ff;
      mem_wr_data = new_ff;
      sq_cmd.op = SQ_IDLE;
      sq_cmd.old_fill = old_ff;
      sq_cmd.new_fill = new_ff;
      res_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               size_in = req_size;
               last_in = req_last;
               rd_idx_in = '0;
               pend_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            mem_rd_en = issue;
            if (pend_ff && fit) begin
               chosen_in = pend_idx_ff;
               old_in = mem_rd_data;
               new_in = mem_rd_data + size_ff;
               opened_in = 1'b0;
               ovf_in = 1'b0;
               state_in = ST_SQ_OLD;
            end else if (!issue) begin
               if (count_ff < CNT_W'(MAX_BINS)) begin
                  chosen_in = count_ff[BIN_W-1:0];
                  old_in = '0;
                  new_in = size_ff;
                  opened_in = 1'b1;
                  ovf_in = 1'b0;
                  count_in = count_ff + 1'b1;
                  state_in = ST_SQ_OLD;
               end else begin
                  chosen_in = '0;
                  opened_in = 1'b0;
                  ovf_in = 1'b1;
                  state_in = ST_DONE;
               end
            end else begin
               rd_idx_in = rd_idx_ff + 1'b1;
               pend_in = 1'b1;
               pend_idx_in = rd_idx_ff[BIN_W-1:0];
            end
         end
         ST_SQ_OLD: begin
            mem_wr_en = 1'b1;
            sq_cmd.op = SQ_LOAD_OLD;
            state_in = ST_SQ_NEW;
         end
         ST_SQ_NEW: begin
            sq_cmd.op = SQ_SUB;
            state_in = ST_SQ_ADD;
         end
         ST_SQ_ADD: begin
            sq_cmd.op = SQ_ADD;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               res_valid = 1'b1;
               if (last_ff) begin
                  count_in = '0;
                  sq_cmd.op = SQ_CLEAR;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      pend_idx_ff <= pend_idx_in;
      chosen_ff <= chosen_in;
      size_ff <= size_in;
      last_ff <= last_in;
      old_ff <= old_in;
      new_ff <= new_in;
      opened_ff <= opened_in;
      ovf_ff <= ovf_in;
   end

   always_comb begin
      chosen_wide = 32'(chosen_ff);
      count_wide = 32'(count_ff);
      result.bin_sel = chosen_wide[IDX_OUT_W-1:0];
      result.opened_new_bin = opened_ff;
      result.bins_used = count_wide[USED_W-1:0];
      result.overflow = ovf_ff;
      result.packing_done = last_ff;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BINS))
      else $error("bin count exceeds the number of bins");

   a_write_open_bin: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> CNT_W'(mem_wr_addr) < count_ff)
      else $error("fill written to a bin that is not open");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_SCAN)
      else $error("accepted item did not start a scan");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      res_valid && last_ff |=> count_ff == '0)
      else $error("bin count not cleared after the last item");

   a_ovf_not_opened: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !(ovf_ff && opened_ff))
      else $error("dropped item reported as opening a bin");

endmodule

FILE: src/first_fit_bin_packer.sv
// First-fit bin packer. Item sizes arrive on the req_ stream (size in tdata,
// tlast marks the final item of a packing); one result leaves on the rsp_
// stream for every item. The user must write the capacity register through
// csr_wr_en and csr_wr_data only while the block is idle; this is unchecked.
// The bin fills live in a one-port-read, one-port-write memory. The scan reads
// one bin per cycle in order until it finds a bin with room; an item that fits
// an open bin or opens a new one then steps through ST_SQ_OLD, ST_SQ_NEW and
// ST_SQ_ADD to update the square sum before ST_DONE loads its result into the
// output register, while a dropped item goes from the scan straight to ST_DONE.
// One item is worked at a time; the next can be taken once the previous result
// is loaded into the output register, even while that result waits.
// A stalled receiver holds the result in the output register; the next item
// then finishes its scan and waits until the register is free.
// Reset empties all bins, zeros the square sum and sets the capacity to its
// maximum. No clearing pass is needed: only bins below the count are read.
// After a tlast transfer the bins and square sum clear as its result is loaded.
module first_fit_bin_packer #(
   parameter int MAX_BINS = ffbp_pkg::DEFAULT_MAX_BINS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // item_size[15:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // bin_sel[7:0], bins_used[16:8],
                                    // fill_square_sum[56:17], zero[63:57]
   output logic [1:0]  rsp_tuser,   // opened_new_bin[0], overflow[1]
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import ffbp_pkg::*;

   localparam int BIN_W = $clog2(MAX_BINS);
   localparam int CNT_W = $clog2(MAX_BINS + 1);

   logic [FILL_W-1:0] cap_ff;
   logic              mem_rd_en;
   logic [BIN_W-1:0]  mem_rd_addr;
   logic [FILL_W-1:0] mem_rd_data;
   logic              mem_wr_en;
   logic [BIN_W-1:0]  mem_wr_addr;
   logic [FILL_W-1:0] mem_wr_data;
   sq_cmd_type        sq_cmd;
   logic [SUM_W-1:0]  square_sum;
   logic              out_free;
   logic              res_valid;
   result_type        result;
   logic              rsp_valid_ff;
   result_type        rsp_res_ff;
   logic [SUM_W-1:0]  rsp_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   ffbp_fill_mem #(
      .DEPTH  (MAX_BINS),
      .ADDR_W (BIN_W)
   ) u_fill_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ffbp_sq_acc u_sq_acc (
      .clock      (clock),
      .reset      (reset),
      .cmd        (sq_cmd),
      .square_sum (square_sum)
   );

   ffbp_scan #(
      .MAX_BINS (MAX_BINS),
      .BIN_W    (BIN_W),
      .CNT_W    (CNT_W)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .capacity    (cap_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_size    (req_tdata),
      .req_last    (req_tlast),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .sq_cmd      (sq_cmd),
      .out_free    (out_free),
      .res_valid   (res_valid),
      .result      (result)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_res_ff <= result;
         rsp_sum_ff <= square_sum;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {7'b0, rsp_sum_ff, rsp_res_ff.bins_used, rsp_res_ff.bin_sel};
   assign rsp_tuser = {rsp_res_ff.overflow, rsp_res_ff.opened_new_bin};
   assign rsp_tlast = rsp_res_ff.packing_done;

endmodule
